[sv/shfr_pkg.sv]
// Shared constants and types for the sync-header frame receiver.
`default_nettype none
package shfr_pkg;

    localparam int unsigned BYTE_W = 8;
    // Wide enough to compare a position that may equal the store depth with a length byte.
    localparam int unsigned CMP_W = BYTE_W + 1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;
    localparam logic [BYTE_W-1:0] MIN_LENGTH  = 8'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SUM  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

endpackage
`default_nettype wire

[sv/shfr_store.sv]
// Frame byte store: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module shfr_store #(
    parameter int unsigned BUFFER_DEPTH = 128,
    parameter int unsigned AW = 7
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr_en,
    input  wire logic [AW-1:0]                   i_wr_addr,
    input  wire logic [shfr_pkg::BYTE_W-1:0]     i_wr_data,
    input  wire logic                            i_rd_en,
    input  wire logic [AW-1:0]                   i_rd_addr,
    output logic      [shfr_pkg::BYTE_W-1:0]     o_rd_data
);

    logic [shfr_pkg::BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0]     r_vld;
    logic [shfr_pkg::BYTE_W-1:0] r_rd_data;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

[sv/sync_header_frame_receiver_top.sv]
// Sync-header frame receiver top level: byte intake, frame tracking and checksum walk.
// A frame of length L >= 3 is checked by walking store entries 0..L-2 through the one read port;
// a shorter frame goes straight to the result register. Intake takes one byte per cycle while
// idle; once a frame completes, intake stalls until the check is done and the result has
// been handed to the output, which waits while an earlier result is held by i_stall.
// Reset: synchronous active low; clears position, header mark, valid bits and the output valid flag.
`default_nettype none
module sync_header_frame_receiver_top #(
    parameter int unsigned BUFFER_DEPTH = 128
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [shfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_checksum_ok,
    output logic      [shfr_pkg::BYTE_W-1:0] o_frame_type,
    output logic      [shfr_pkg::BYTE_W-1:0] o_frame_length
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned BW = shfr_pkg::BYTE_W;
    localparam int unsigned CW = shfr_pkg::CMP_W;

    shfr_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_pos, n_pos;
    logic          r_hdr, n_hdr;
    logic [BW-1:0] r_len, n_len;     // mirror of store entry 0
    logic [BW-1:0] r_type, n_type;   // mirror of store entry 1

    logic [AW-1:0] r_iss_addr, n_iss_addr;
    logic          r_iss_done, n_iss_done;
    logic          r_got, n_got;
    logic [AW-1:0] r_use_addr, n_use_addr;
    logic [BW-1:0] r_sum, n_sum;
    logic [BW-1:0] r_last, n_last;

    logic [BW-1:0] r_res_len, n_res_len;
    logic [BW-1:0] r_res_type, n_res_type;
    logic          r_res_ok, n_res_ok;

    logic          r_o_valid, n_o_valid;
    logic          r_o_ok, n_o_ok;
    logic [BW-1:0] r_o_type, n_o_type;
    logic [BW-1:0] r_o_len, n_o_len;

    logic          wr_en;
    logic          rd_en;
    logic [BW-1:0] rd_data;
    logic          accept;
    logic [AW:0]   pos_inc;
    logic [AW-1:0] pos_sat;
    logic          out_free;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    assign pos_sat  = (pos_inc == (AW+1)'(BUFFER_DEPTH)) ? AW'(BUFFER_DEPTH - 1) : pos_inc[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_len      = r_len;
        n_type     = r_type;
        n_iss_addr = r_iss_addr;
        n_iss_done = r_iss_done;
        n_got      = 1'b0;
        n_use_addr = r_use_addr;
        n_sum      = r_sum;
        n_last     = r_last;
        n_res_len  = r_res_len;
        n_res_type = r_res_type;
        n_res_ok   = r_res_ok;
        n_o_valid  = r_o_valid && i_stall;
        n_o_ok     = r_o_ok;
        n_o_type   = r_o_type;
        n_o_len    = r_o_len;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        unique case (r_state)
            shfr_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_rx_byte == shfr_pkg::SYNC_SECOND && r_hdr) begin
                        n_pos = '0;
                    end else begin
                        wr_en = 1'b1;
                        n_pos = pos_sat;
                        if (r_pos == AW'(0)) begin
                            n_len = i_rx_byte;
                        end
                        if (r_pos == AW'(1)) begin
                            n_type = i_rx_byte;
                        end
                    end
                    n_hdr = (i_rx_byte == shfr_pkg::SYNC_FIRST);
                    if (i_rx_byte != shfr_pkg::SYNC_FIRST && i_rx_byte != shfr_pkg::SYNC_SECOND
                        && CW'(pos_inc) == CW'(n_len)) begin
                        n_res_len  = n_len;
                        n_res_type = n_type;
                        n_res_ok   = 1'b0;
                        if (n_len < shfr_pkg::MIN_LENGTH) begin
                            n_state = shfr_pkg::S_PUSH;
                        end else begin
                            n_last     = n_len - 8'd2;
                            n_iss_addr = '0;
                            n_iss_done = 1'b0;
                            n_use_addr = '0;
                            n_sum      = '0;
                            n_state    = shfr_pkg::S_SUM;
                        end
                    end
                end
            end
            shfr_pkg::S_SUM: begin
                // Reads are issued one per cycle; each read's data is back in the next cycle.
                if (!r_iss_done) begin
                    rd_en = 1'b1;
                    n_got = 1'b1;
                    if (r_iss_addr == AW'(r_last)) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_iss_addr = r_iss_addr + 1'b1;
                    end
                end
                if (r_got) begin
                    if (r_use_addr == AW'(r_last)) begin
                        n_res_ok = (r_sum == rd_data);
                        n_got    = 1'b0;
                        n_state  = shfr_pkg::S_PUSH;
                    end else begin
                        n_sum      = r_sum + rd_data;
                        n_use_addr = r_use_addr + 1'b1;
                    end
                end
            end
            shfr_pkg::S_PUSH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = r_res_ok;
                    n_o_type  = r_res_type;
                    n_o_len   = r_res_len;
                    n_state   = shfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = shfr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= shfr_pkg::S_IDLE;
            r_pos      <= '0;
            r_hdr      <= 1'b0;
            r_len      <= '0;
            r_type     <= '0;
            r_iss_done <= 1'b1;
            r_got      <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_hdr      <= n_hdr;
            r_len      <= n_len;
            r_type     <= n_type;
            r_iss_done <= n_iss_done;
            r_got      <= n_got;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss_addr <= n_iss_addr;
        r_use_addr <= n_use_addr;
        r_sum      <= n_sum;
        r_last     <= n_last;
        r_res_len  <= n_res_len;
        r_res_type <= n_res_type;
        r_res_ok   <= n_res_ok;
        r_o_ok     <= n_o_ok;
        r_o_type   <= n_o_type;
        r_o_len    <= n_o_len;
    end

    shfr_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_iss_addr),
        .o_rd_data (rd_data)
    );

    assign o_stall        = (r_state != shfr_pkg::S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_checksum_ok  = r_o_ok;
    assign o_frame_type   = r_o_type;
    assign o_frame_length = r_o_len;

endmodule
`default_nettype wire

[dv/frame_report_checker.sv]
`timescale 1ns / 100ps
// Scoreboard that predicts and checks the frame reports of the sync-header frame receiver.
module frame_report_checker
    import shfr_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic              i_checksum_ok,
    input  wire logic [BYTE_W-1:0] i_frame_type,
    input  wire logic [BYTE_W-1:0] i_frame_length,
    output int unsigned            o_errors,
    output int unsigned            o_outstanding
);

    typedef struct packed {
        logic              checksum_ok;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_length;
    } frame_report_t;

    logic [BYTE_W-1:0] frame_mem [BUFFER_DEPTH];
    int unsigned       wr_pos;
    bit                sync_armed;
    int unsigned       err_cnt;
    frame_report_t     expected_reports [$];

    function automatic void put_byte(input logic [BYTE_W-1:0] b);
        if (wr_pos < BUFFER_DEPTH) frame_mem[wr_pos] = b;
        wr_pos++;
    endfunction

    // Updates the frame state with one byte; returns 1 when that byte completes a frame.
    function automatic bit absorb_byte(input logic [BYTE_W-1:0] b, output frame_report_t rpt);
        int unsigned       len;
        logic [BYTE_W-1:0] sum;
        bit                done;
        done = 1'b0;
        rpt  = '0;
        if (b == SYNC_FIRST) begin
            sync_armed = 1'b1;
            put_byte(b);
        end else if (b == SYNC_SECOND) begin
            // A header pair only rewinds the position; the stored bytes stay.
            if (sync_armed) wr_pos = 0;
            else put_byte(b);
            sync_armed = 1'b0;
        end else begin
            put_byte(b);
            sync_armed = 1'b0;
            len = 32'(frame_mem[0]);
            // The position is compared before saturation, so it can equal the depth here.
            if (wr_pos == len) begin
                done = 1'b1;
                sum  = '0;
                if (len >= MIN_LENGTH) begin
                    for (int k = 0; k < len - 2; k++) sum += frame_mem[k];
                    rpt.checksum_ok = (sum == frame_mem[len - 2]);
                end
                rpt.frame_type   = frame_mem[1];
                rpt.frame_length = len[BYTE_W-1:0];
            end
        end
        if (wr_pos >= BUFFER_DEPTH) wr_pos = BUFFER_DEPTH - 1;
        return done;
    endfunction

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        frame_report_t got;
        frame_report_t want;
        frame_report_t rpt;
        if (!i_rst_n) begin
            foreach (frame_mem[k]) frame_mem[k] = '0;
            wr_pos     = 0;
            sync_armed = 1'b0;
            err_cnt    = 0;
            expected_reports.delete();
        end else begin
            // Results are checked first so that a byte taken at this edge cannot match itself.
            if (i_out_valid && !i_out_stall) begin
                got.checksum_ok  = i_checksum_ok;
                got.frame_type   = i_frame_type;
                got.frame_length = i_frame_length;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report: expected none actual ok=%0d type=%0d len=%0d",
                             $time, got.checksum_ok, got.frame_type, got.frame_length);
                    err_cnt++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("checksum_ok", BYTE_W'(want.checksum_ok),
                                BYTE_W'(got.checksum_ok));
                    check_field("frame_type", want.frame_type, got.frame_type);
                    check_field("frame_length", want.frame_length, got.frame_length);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (absorb_byte(i_rx_byte, rpt)) expected_reports.push_back(rpt);
            end
        end
        o_errors      <= err_cnt;
        o_outstanding <= expected_reports.size();
    end

endmodule

[dv/sync_header_frame_receiver_top_test.sv]
`timescale 1ns / 100ps
// Testbench top for the sync-header frame receiver: stimulus, idling, watchdog and verdict.
module sync_header_frame_receiver_top_test;
    import shfr_pkg::*;

    localparam int unsigned STORE_DEPTH    = 128;
    localparam int unsigned ITEM_TARGET    = 1150;
    localparam int unsigned CALM_TX_START  = 300;
    localparam int unsigned CALM_TX_END    = 600;
    localparam int unsigned HOLD_START     = 600;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned CALM_RX_START  = 1300;
    localparam int unsigned CALM_RX_END    = 1900;
    localparam int unsigned DRAIN_CYCLES   = 300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              i_stall   = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_checksum_ok;
    logic [BYTE_W-1:0] o_frame_type;
    logic [BYTE_W-1:0] o_frame_length;
    int unsigned       err_count;
    int unsigned       pending_reports;
    int unsigned       n_sent = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sync_header_frame_receiver_top #(
        .BUFFER_DEPTH (STORE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_checksum_ok  (o_checksum_ok),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length)
    );

    frame_report_checker #(
        .BUFFER_DEPTH (STORE_DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_checksum_ok  (o_checksum_ok),
        .i_frame_type   (o_frame_type),
        .i_frame_length (o_frame_length),
        .o_errors       (err_count),
        .o_outstanding  (pending_reports)
    );

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do begin
            b = BYTE_W'($urandom_range(255));
        end while (b == SYNC_FIRST || b == SYNC_SECOND);
        return b;
    endfunction

    // Offers one byte and returns at the edge where the transaction completes.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ((n_sent < CALM_TX_START || n_sent >= CALM_TX_END) && $urandom_range(99) < 25)
        begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        n_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] len);
        int unsigned       n;
        int unsigned       cut;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] prev;
        logic [BYTE_W-1:0] sum;
        n    = 32'(len);
        // Now and then the frame is broken off early.
        cut  = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : 256;
        sum  = len;
        prev = len;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len);
        if (n < MIN_LENGTH || n > STORE_DEPTH) begin
            repeat ($urandom_range(0, 4)) send_byte(BYTE_W'($urandom_range(255)));
        end else begin
            for (int k = 1; k < n && k < cut; k++) begin
                if (k == n - 1) begin
                    b = plain_byte();
                end else if (k == n - 2) begin
                    b = ($urandom_range(7) == 0) ? BYTE_W'($urandom_range(255)) : sum;
                end else begin
                    b = BYTE_W'($urandom_range(255));
                    // Mostly keep a header pair out of the body so the frame gets through.
                    if (prev == SYNC_FIRST && b == SYNC_SECOND && $urandom_range(3) != 0)
                        b = 8'h5B;
                    sum += b;
                end
                send_byte(b);
                prev = b;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off that backs up the input, one calm stretch.
    initial begin : report_sink
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) i_stall <= 1'b1;
            else if (cyc >= CALM_RX_START && cyc < CALM_RX_END) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(99) < 25);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("** sync_header_frame_receiver_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] directed_bytes [$];
        logic [BYTE_W-1:0] len;
        int unsigned       pick;
        directed_bytes = '{
            SYNC_SECOND,                                          // lone 0x5A stored as data
            SYNC_FIRST, SYNC_SECOND, 8'h01,                       // length one, stale type
            SYNC_FIRST, SYNC_SECOND, 8'h02, 8'hFF,                // length two, checksum fails
            SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h33,                // length zero never completes
            SYNC_FIRST, SYNC_SECOND, 8'h04, 8'h10, 8'h14, 8'h7E,  // good four-byte frame
            SYNC_FIRST, SYNC_SECOND, 8'h03, 8'h03, 8'h80          // shortest checked frame
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);

        // A full-length frame, then bytes that keep completing it while the store is full.
        send_frame(8'd128);
        repeat (4) send_byte(plain_byte());
        send_frame(8'd127);
        while (n_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 84) len = BYTE_W'($urandom_range(3, 24));
            else if (pick < 90) len = BYTE_W'($urandom_range(0, 2));
            else if (pick < 93) len = BYTE_W'($urandom_range(100, STORE_DEPTH));
            else len = BYTE_W'($urandom_range(25, 255));
            send_frame(len);
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_reports != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_reports == 0)
            $display("** sync_header_frame_receiver_top: PASSED **");
        else
            $display("** sync_header_frame_receiver_top: FAILED **");
        $finish;
    end

endmodule
